// ===== hw/rtl/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, codes and default sizes of the canonical Huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam int MAX_SYMBOLS_DEF  = 512;
	localparam int MAX_CODE_LEN_DEF = 15;
	localparam int SYMBOL_BITS_DEF  = 10;

	localparam int FUNC_W = 2;
	localparam int SYM_W  = 10;
	localparam int LEN_W  = 4;
	localparam int STAT_W = 2;
	localparam int CODE_W = 16;

	localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FINAL  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DECODE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] ST_SYMBOL  = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_FINAL   = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SYM_W-1:0]  symbol_value;
		logic [LEN_W-1:0]  code_length;
		logic              code_bit;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0]  decoded_symbol;
		logic [STAT_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic load;
		logic clear;
	} entry_cmd_t;

endpackage

// ===== hw/rtl/canonical_huffman_decoder_top.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_top
// Canonical Huffman decoder with count and first-code tables.
// ----------------------------------------------------------------------------
// Load words append (symbol, length) pairs to the entry memory; a zero
// length, or one above MAX_CODE_LEN, is dropped silently, and any other
// load into a full list answers "table full". A finalize word sweeps the
// entry memory twice, once to count the codes of each length and once to
// place the symbols in canonical order, with a pass over the lengths between
// the two sweeps to form the first index of each length; the input is held
// off from the word being taken until the "finalize done" answer enters the
// output register, which waits while that register is stalled. A decode
// word carries one code bit, most significant first: a bit that completes a
// code reads the sorted symbol memory and passes through a symbol state that
// puts the symbol in the output register. A prefix with no possible
// continuation answers "invalid" and decoding starts over. Results sit in an
// output register, so the next word is taken while a result waits unless
// that register is stalled.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder_top import chd_pkg::*; #(
	parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int SYMBOL_BITS  = SYMBOL_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int AW = $clog2(MAX_SYMBOLS);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam int LW = $clog2(MAX_CODE_LEN + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CNT   = 3'd1;
	localparam logic [2:0] S_PFX   = 3'd2;
	localparam logic [2:0] S_PLACE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_SYM   = 3'd5;

	logic [2:0]        state_q;
	logic [CW-1:0]     counts_q [1:MAX_CODE_LEN];
	logic [CW-1:0]     next_q   [1:MAX_CODE_LEN];
	logic [CW-1:0]     total_q;
	logic [CW-1:0]     run_q;
	logic [LW-1:0]     longest_q;
	logic [LW-1:0]     pfx_len_q;
	logic [CW-1:0]     iss_q;
	logic              pend_s1;

	// Running canonical decode state.
	logic [CODE_W-1:0] acc_q;
	logic [CODE_W-1:0] first_q;
	logic [CW-1:0]     base_q;
	logic [LW-1:0]     cur_q;

	logic              res_v_q;
	result_t           res_q;
	logic              res_set;
	result_t           res_d;

	logic              accept;
	logic              slot_free;

	entry_cmd_t             ent_cmd;
	logic [CW-1:0]          ent_count;
	logic                   ent_rd_en;
	logic [SYMBOL_BITS-1:0] ent_rd_sym;
	logic [LEN_W-1:0]       ent_rd_len;
	logic                   len_ok;

	logic                   srt_wr_en;
	logic [AW-1:0]          srt_wr_addr;
	logic                   srt_rd_en;
	logic [SYMBOL_BITS-1:0] srt_rd_sym;

	logic [CODE_W-1:0] acc_n;
	logic [CODE_W-1:0] diff;
	logic [CW-1:0]     cnt_cur;
	logic              hit;
	logic [CW-1:0]     idx;
	logic              sweep_more;

	assign slot_free    = !(res_v_q && result_stall);
	assign item_stall   = (state_q != S_IDLE) || !slot_free;
	assign accept       = item_valid && !item_stall;
	assign result_valid = res_v_q;
	assign result       = res_q;

	assign len_ok = (item.code_length != '0) &&
		(32'(item.code_length) <= MAX_CODE_LEN);

	assign ent_cmd.load  = accept && (item.func == FN_LOAD) && len_ok &&
		(32'(ent_count) < MAX_SYMBOLS);
	assign ent_cmd.clear = accept && (item.func == FN_CLEAR);

	assign sweep_more = 32'(iss_q) < 32'(ent_count);
	assign ent_rd_en  = ((state_q == S_CNT) || (state_q == S_PLACE)) && sweep_more;

	// Decode arithmetic for the current bit.
	assign cnt_cur = counts_q[cur_q];
	assign acc_n   = acc_q | CODE_W'(item.code_bit);
	assign diff    = acc_n - first_q;
	assign hit     = (acc_n >= first_q) && (diff < CODE_W'(cnt_cur));
	assign idx     = base_q + diff[CW-1:0];

	assign srt_wr_en   = (state_q == S_PLACE) && pend_s1 && (ent_rd_len != '0);
	assign srt_wr_addr = next_q[ent_rd_len[LW-1:0]][AW-1:0];
	assign srt_rd_en   = accept && (item.func == FN_DECODE) &&
		(cur_q <= longest_q) && hit && (idx < total_q);

	chd_entry_store #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.SYMBOL_BITS (SYMBOL_BITS),
		.AW          (AW),
		.CW          (CW)
	) u_entries (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ent_cmd),
		.wr_symbol (SYMBOL_BITS'(item.symbol_value)),
		.wr_length (item.code_length),
		.count     (ent_count),
		.rd_en     (ent_rd_en),
		.rd_addr   (iss_q[AW-1:0]),
		.rd_symbol (ent_rd_sym),
		.rd_length (ent_rd_len)
	);

	chd_sorted_store #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.SYMBOL_BITS (SYMBOL_BITS),
		.AW          (AW)
	) u_sorted (
		.clk       (clk),
		.wr_en     (srt_wr_en),
		.wr_addr   (srt_wr_addr),
		.wr_symbol (ent_rd_sym),
		.rd_en     (srt_rd_en),
		.rd_addr   (idx[AW-1:0]),
		.rd_symbol (srt_rd_sym)
	);

	// Result produced by this cycle's work, if any.
	always_comb begin
		res_set = 1'b0;
		res_d   = '0;
		if (accept) begin
			case (item.func)
				FN_LOAD: begin
					if (len_ok && (32'(ent_count) >= MAX_SYMBOLS)) begin
						res_set   = 1'b1;
						res_d.status = ST_FULL;
					end
				end
				FN_DECODE: begin
					if (cur_q > longest_q) begin
						res_set      = 1'b1;
						res_d.status = ST_INVALID;
					end else if (hit) begin
						if (idx >= total_q) begin
							res_set      = 1'b1;
							res_d.status = ST_INVALID;
						end
					end else if (cur_q >= longest_q) begin
						res_set      = 1'b1;
						res_d.status = ST_INVALID;
					end
				end
				default: begin
				end
			endcase
		end else if ((state_q == S_FIN) && slot_free) begin
			res_set      = 1'b1;
			res_d.status = ST_FINAL;
		end else if ((state_q == S_SYM) && slot_free) begin
			res_set              = 1'b1;
			res_d.status         = ST_SYMBOL;
			res_d.decoded_symbol = SYM_W'(srt_rd_sym);
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_set) begin
			res_v_q <= 1'b1;
		end else if (!result_stall) begin
			res_v_q <= 1'b0;
		end
	end

	// Control sequencer, table registers and decode state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			counts_q  <= '{default: '0};
			next_q    <= '{default: '0};
			total_q   <= '0;
			run_q     <= '0;
			longest_q <= '0;
			pfx_len_q <= '0;
			iss_q     <= '0;
			pend_s1   <= 1'b0;
			acc_q     <= '0;
			first_q   <= '0;
			base_q    <= '0;
			cur_q     <= LW'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.func)
							FN_FINAL: begin
								counts_q <= '{default: '0};
								iss_q    <= '0;
								pend_s1  <= 1'b0;
								state_q  <= S_CNT;
							end
							FN_CLEAR: begin
								counts_q  <= '{default: '0};
								total_q   <= '0;
								longest_q <= '0;
								acc_q     <= '0;
								first_q   <= '0;
								base_q    <= '0;
								cur_q     <= LW'(1);
							end
							FN_DECODE: begin
								if ((cur_q > longest_q) || hit || (cur_q >= longest_q)) begin
									acc_q   <= '0;
									first_q <= '0;
									base_q  <= '0;
									cur_q   <= LW'(1);
									if ((cur_q <= longest_q) && hit && (idx < total_q)) begin
										state_q <= S_SYM;
									end
								end else begin
									base_q  <= base_q + cnt_cur;
									first_q <= (first_q + CODE_W'(cnt_cur)) << 1;
									acc_q   <= acc_n << 1;
									cur_q   <= cur_q + 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CNT: begin
					pend_s1 <= sweep_more;
					if (sweep_more) begin
						iss_q <= iss_q + 1'b1;
					end
					if (pend_s1) begin
						counts_q[ent_rd_len[LW-1:0]] <= counts_q[ent_rd_len[LW-1:0]] + 1'b1;
					end
					if (!sweep_more && !pend_s1) begin
						pfx_len_q <= LW'(1);
						run_q     <= '0;
						longest_q <= '0;
						state_q   <= S_PFX;
					end
				end
				S_PFX: begin
					next_q[pfx_len_q] <= run_q;
					run_q             <= run_q + counts_q[pfx_len_q];
					if (counts_q[pfx_len_q] != '0) begin
						longest_q <= pfx_len_q;
					end
					pfx_len_q <= pfx_len_q + 1'b1;
					if (32'(pfx_len_q) == MAX_CODE_LEN) begin
						total_q <= run_q + counts_q[pfx_len_q];
						iss_q   <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					pend_s1 <= sweep_more;
					if (sweep_more) begin
						iss_q <= iss_q + 1'b1;
					end
					if (srt_wr_en) begin
						next_q[ent_rd_len[LW-1:0]] <= next_q[ent_rd_len[LW-1:0]] + 1'b1;
					end
					if (!sweep_more && !pend_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						acc_q   <= '0;
						first_q <= '0;
						base_q  <= '0;
						cur_q   <= LW'(1);
						state_q <= S_IDLE;
					end
				end
				S_SYM: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Only a decoded symbol carries a non-zero symbol field.
	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && (res_q.status != ST_SYMBOL)) |-> (res_q.decoded_symbol == '0))
		else $error("non-symbol result carries a symbol");

	// The code length being decoded stays within the legal range.
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q >= LW'(1)) && (32'(cur_q) <= MAX_CODE_LEN))
		else $error("current code length out of range");

	// Entry memory read data is only expected during the two sweeps.
	a_pend_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> ((state_q == S_CNT) || (state_q == S_PLACE)))
		else $error("entry read pending outside a sweep");

	// A completed code always goes on to the symbol read state.
	a_sym_read: assert property (@(posedge clk) disable iff (!arst_n)
		srt_rd_en |=> (state_q == S_SYM))
		else $error("symbol read without symbol state");

endmodule

// ===== hw/rtl/chd_entry_store.sv =====
// ----------------------------------------------------------------------------
// chd_entry_store
// Entry list memory of loaded (symbol, length) pairs with its fill count.
// ----------------------------------------------------------------------------
module chd_entry_store import chd_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
	parameter int AW = $clog2(MAX_SYMBOLS),
	parameter int CW = $clog2(MAX_SYMBOLS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  entry_cmd_t             cmd,
	input  logic [SYMBOL_BITS-1:0] wr_symbol,
	input  logic [LEN_W-1:0]       wr_length,
	output logic [CW-1:0]          count,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output logic [SYMBOL_BITS-1:0] rd_symbol,
	output logic [LEN_W-1:0]       rd_length
);

	logic [SYMBOL_BITS+LEN_W-1:0] mem [MAX_SYMBOLS];
	logic [CW-1:0]                count_q;

	assign count = count_q;

	// The caller only loads while the count is below the depth.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[count_q[AW-1:0]] <= {wr_symbol, wr_length};
		end
		if (rd_en) begin
			{rd_symbol, rd_length} <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_q + 1'b1;
		end
	end

endmodule

// ===== hw/rtl/chd_sorted_store.sv =====
// ----------------------------------------------------------------------------
// chd_sorted_store
// Memory of symbols in canonical order, written by finalize, read by decode.
// ----------------------------------------------------------------------------
module chd_sorted_store import chd_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
	parameter int AW = $clog2(MAX_SYMBOLS)
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [SYMBOL_BITS-1:0] wr_symbol,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output logic [SYMBOL_BITS-1:0] rd_symbol
);

	logic [SYMBOL_BITS-1:0] mem [MAX_SYMBOLS];

	// Read data holds until the next read, so a stalled result can wait on it.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_symbol;
		end
		if (rd_en) begin
			rd_symbol <= mem[rd_addr];
		end
	end

endmodule

// ===== sim/tb_canonical_huffman_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_canonical_huffman_decoder_top
// Self-checking bench for the canonical Huffman decoder.
// ----------------------------------------------------------------------------
// A directed table covers reset behaviour, the load special cases,
// empty-table decoding and a small complete code; a directed run fills the
// entry list. Random sets of lengths are then loaded, finalised and decoded
// with random codes and noise bits. Every result word is compared with the
// output of a behavioural model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_canonical_huffman_decoder_top;
	import chd_pkg::*;

	localparam int ENTRY_DEPTH = MAX_SYMBOLS_DEF;
	localparam int LONGEST_LEN = MAX_CODE_LEN_DEF;
	localparam int WATCHDOG    = 20000;
	localparam int HOLD_CYCLES = 300;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	canonical_huffman_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Behavioural copy of the decoder state.
	logic [SYM_W-1:0]  ent_sym [ENTRY_DEPTH];
	logic [LEN_W-1:0]  ent_len [ENTRY_DEPTH];
	int                ent_cnt;
	int                len_cnt [16];
	logic [SYM_W-1:0]  canon_sym [ENTRY_DEPTH];
	logic [CODE_W-1:0] acc;
	int                cur_len;
	logic [CODE_W-1:0] first;
	int                base;

	result_t expected_q[$];
	int      errors;
	// Idle percentages of the sender and of the receiver.
	int      sender_mode;
	int      receiver_mode;
	bit      hold_req;
	bit      hold_done;
	int      hold_left;
	int      idle_cycles;

	function automatic void restart_decode();
		acc     = '0;
		cur_len = 1;
		first   = '0;
		base    = 0;
	endfunction

	function automatic void queue_expect(result_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	// Works out the response to one accepted word and queues it, if any.
	function automatic void predict_word(item_t w);
		result_t r;
		int      nxt [16];
		int      total;
		int      longest;
		int      cnt;
		int      idx;
		r = '0;
		case (w.func)
			FN_LOAD: begin
				if (w.code_length == 0 || w.code_length > LONGEST_LEN)
					return;
				if (ent_cnt >= ENTRY_DEPTH) begin
					r.status = ST_FULL;
					queue_expect(r);
					return;
				end
				ent_sym[ent_cnt] = w.symbol_value;
				ent_len[ent_cnt] = w.code_length;
				ent_cnt++;
			end
			FN_FINAL: begin
				foreach (len_cnt[l])
					len_cnt[l] = 0;
				for (int i = 0; i < ent_cnt; i++)
					len_cnt[ent_len[i]]++;
				len_cnt[0] = 0;
				total = 0;
				for (int l = 1; l < 16; l++) begin
					nxt[l] = total;
					total += len_cnt[l];
				end
				for (int i = 0; i < ent_cnt; i++) begin
					if (ent_len[i] != 0) begin
						canon_sym[nxt[ent_len[i]]] = ent_sym[i];
						nxt[ent_len[i]]++;
					end
				end
				restart_decode();
				r.status = ST_FINAL;
				queue_expect(r);
			end
			FN_CLEAR: begin
				ent_cnt = 0;
				foreach (len_cnt[l])
					len_cnt[l] = 0;
				restart_decode();
			end
			default: begin
				longest = 0;
				total   = 0;
				for (int l = 1; l <= LONGEST_LEN; l++) begin
					if (len_cnt[l] != 0)
						longest = l;
					total += len_cnt[l];
				end
				if (cur_len > longest) begin
					restart_decode();
					r.status = ST_INVALID;
					queue_expect(r);
					return;
				end
				acc = acc | CODE_W'(w.code_bit);
				cnt = len_cnt[cur_len];
				if (acc >= first && int'(acc - first) < cnt) begin
					idx = base + int'(acc - first);
					restart_decode();
					if (idx >= total || idx >= ENTRY_DEPTH) begin
						r.status = ST_INVALID;
					end else begin
						r.decoded_symbol = canon_sym[idx];
						r.status         = ST_SYMBOL;
					end
					queue_expect(r);
					return;
				end
				if (cur_len >= longest) begin
					restart_decode();
					r.status = ST_INVALID;
					queue_expect(r);
					return;
				end
				base    += cnt;
				first   = (first + CODE_W'(cnt)) << 1;
				acc     = acc << 1;
				cur_len++;
			end
		endcase
	endfunction

	// Result checking: the oldest expectation is compared with every word.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, symbol %0d status %0d", $time,
					result.decoded_symbol, result.status);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (result.decoded_symbol !== exp_r.decoded_symbol) begin
					$display("%0t: decoded_symbol expected %0d actual %0d", $time,
						exp_r.decoded_symbol, result.decoded_symbol);
					errors++;
				end
				if (result.status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, result.status);
					errors++;
				end
			end
		end
	end

	// The receiver stalls according to the current mode, or for a long
	// stretch once a hold-off is requested, counted here in its own cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			result_stall <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			hold_done    <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < receiver_mode);
		end
	end

	// Watchdog on cycles without any accepted word on either side.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("canonical_huffman_decoder_top test failed");
			$finish;
		end
	end

	// Offers one word, idling first as the sender mode asks, and returns at
	// the edge that takes it. The stall is looked at mid-cycle, where it is
	// settled, and the model is updated at the accepting edge.
	task automatic send_word(item_t w);
		while ($urandom_range(99) < sender_mode) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(negedge clk);
		while (item_stall)
			@(negedge clk);
		@(posedge clk);
		predict_word(w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic item_t mk(logic [FUNC_W-1:0] f, int s, int l, int b);
		item_t w;
		w.func         = f;
		w.symbol_value = SYM_W'(s);
		w.code_length  = LEN_W'(l);
		w.code_bit     = b[0];
		return w;
	endfunction

	// Loads a random set of lengths, finalises and then feeds a stream of
	// random codes with some noise bits.
	task automatic random_set(int n_bits);
		int          n;
		int          l;
		int          k;
		logic [15:0] code;
		n = $urandom_range(2, 12);
		for (int i = 0; i < n; i++) begin
			l = $urandom_range(1, ($urandom_range(9) == 0) ? LONGEST_LEN : 6);
			send_word(mk(FN_LOAD, $urandom_range(1023), l, $urandom_range(1)));
		end
		if ($urandom_range(3) == 0)
			send_word(mk(FN_LOAD, $urandom_range(1023), 0, $urandom_range(1)));
		send_word(mk(FN_FINAL, $urandom_range(1023), $urandom_range(15), 0));
		k = 0;
		while (k < n_bits) begin
			if ($urandom_range(9) == 0) begin
				send_word(mk(FN_DECODE, $urandom_range(1023), $urandom_range(15),
					$urandom_range(1)));
				k++;
			end else begin
				// Walk a random code of random length, MSB first.
				l    = $urandom_range(1, 8);
				code = 16'($urandom);
				for (int b = l - 1; b >= 0; b--) begin
					send_word(mk(FN_DECODE, $urandom_range(1023), $urandom_range(15),
						code[b]));
					k++;
				end
			end
		end
		if ($urandom_range(4) == 0)
			send_word(mk(FN_CLEAR, $urandom_range(1023), $urandom_range(15), 0));
	endtask

	// Directed words; a typed expectation is checked where it is obvious.
	typedef struct {
		item_t   w;
		bit      has_exp;
		result_t r;
	} directed_row_t;

	directed_row_t directed_rows [$];

	initial begin
		result_t fixed_r;
		errors        = 0;
		idle_cycles   = 0;
		sender_mode   = 0;
		receiver_mode = 0;
		hold_req      = 1'b0;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		ent_cnt       = 0;
		foreach (len_cnt[l])
			len_cnt[l] = 0;
		restart_decode();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty tables give invalid; loads with zero length are dropped.
		directed_rows = '{
			'{mk(FN_DECODE, 0, 0, 1), 1, '{10'd0, ST_INVALID}},
			'{mk(FN_FINAL, 0, 0, 0), 1, '{10'd0, ST_FINAL}},
			'{mk(FN_DECODE, 1023, 15, 0), 1, '{10'd0, ST_INVALID}},
			'{mk(FN_LOAD, 1023, 0, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_LOAD, 1023, 1, 0), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_LOAD, 0, 2, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_LOAD, 682, 3, 0), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_LOAD, 341, 3, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_LOAD, 5, 15, 0), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_FINAL, 0, 0, 0), 1, '{10'd0, ST_FINAL}},
			'{mk(FN_DECODE, 0, 0, 0), 1, '{10'd1023, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 0), 1, '{10'd0, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 1), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_LOAD, 7, 2, 0), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 0), 1, '{10'd0, ST_SYMBOL}},
			'{mk(FN_CLEAR, 0, 0, 0), 0, '{10'd0, ST_SYMBOL}},
			'{mk(FN_DECODE, 0, 0, 0), 1, '{10'd0, ST_INVALID}}
		};
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].w);
			if (directed_rows[i].has_exp) begin
				fixed_r = expected_q[$];
				if (fixed_r !== directed_rows[i].r) begin
					$display("%0t: table row %0d expected %h actual %h", $time, i,
						directed_rows[i].r, fixed_r);
					errors++;
				end
			end
		end
		drain();

		// Fill the entry list to the brim so one more load reports it full.
		for (int i = 0; i < ENTRY_DEPTH; i++)
			send_word(mk(FN_LOAD, $urandom_range(1023), $urandom_range(1, 15), 0));
		send_word(mk(FN_LOAD, 1023, 15, 1));
		send_word(mk(FN_FINAL, 0, 0, 0));
		for (int i = 0; i < 20; i++)
			send_word(mk(FN_DECODE, 0, 0, $urandom_range(1)));
		send_word(mk(FN_CLEAR, 0, 0, 0));
		drain();

		// Random phases: no idling, sender idle, receiver stalling, both, hold-off.
		for (int ph = 0; ph < 5; ph++) begin
			sender_mode   = (ph == 1) ? 70 : ((ph == 3) ? 26 : 0);
			receiver_mode = (ph == 2) ? 70 : ((ph == 3) ? 26 : 0);
			for (int s = 0; s < 3; s++)
				random_set($urandom_range(20, 40));
			if (ph == 4) begin
				// Long receiver hold-off while words keep coming.
				hold_req = 1'b1;
				for (int s = 0; s < 3; s++)
					random_set(30);
			end
			drain();
		end

		if (errors == 0 && expected_q.size() == 0) begin
			$display("canonical_huffman_decoder_top test passed");
		end else begin
			$display("canonical_huffman_decoder_top test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/chd_pkg.sv
hw/rtl/chd_entry_store.sv
hw/rtl/chd_sorted_store.sv
hw/rtl/canonical_huffman_decoder_top.sv
sim/tb_canonical_huffman_decoder_top.sv
